// ===== src/text_to_morse_keyer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Text-to-Morse keyer: assertion macros
// Each macro checks one implication on the rising clock edge and is disabled
// while reset is asserted. The synthesis view defines the macros as empty.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_MORSE_KEYER_UNIT_DEFINES_SVH
`define TEXT_TO_MORSE_KEYER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TMK_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("keyer assertion failed");
// Next-cycle implication.
`define TMK_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("keyer assertion failed");
`else
`define TMK_ASSERT_IMP(lbl, ant, con)
`define TMK_ASSERT_NXT(lbl, ant, con)
`endif

`endif

// ===== src/tmk_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-to-Morse keyer package
// Request, register and state codes, code word constants and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package tmk_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_PUSH  = 2'd1;
  localparam logic [1:0] REQ_TWR   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DOT   = 2'd0;
  localparam logic [1:0] CFG_DASH  = 2'd1;
  localparam logic [1:0] CFG_PTT   = 2'd2;

  // Key states.
  localparam logic [1:0] KEY_UP    = 2'd0;
  localparam logic [1:0] KEY_DIT   = 2'd1;
  localparam logic [1:0] KEY_DAH   = 2'd2;

  // Head prefetch states.
  localparam logic [1:0] HS_IDLE   = 2'd0;
  localparam logic [1:0] HS_QRD    = 2'd1;
  localparam logic [1:0] HS_TRD    = 2'd2;
  localparam logic [1:0] HS_READY  = 2'd3;

  localparam int unsigned CD_W     = 17;
  localparam int unsigned TIME_W   = 16;

  localparam logic [15:0] WORD_GAP_WORD = 16'hD000;
  localparam logic [3:0]  CMD_NIBBLE    = 4'hE;
  localparam logic [7:0]  SPACE_CHAR    = 8'd32;

  // One result item; the last member sits in bit 0.
  typedef struct packed {
    logic [11:0] command_index;
    logic        command_valid;
    logic [7:0]  shown_char;
    logic        shown_valid;
    logic        push_accepted;
    logic        sending;
    logic        key_down;
  } tmk_result_t;

endpackage

`default_nettype wire

// ===== src/text_to_morse_keyer_unit.sv =====
// ----------------------------------------------------------------------------
// Text-to-Morse keyer
// Each input transfer's result is registered in the output register, or in the
// skid stage behind it. Throughput: one item per cycle while the skid stage is
// free; a tick with a nonempty queue waits for the head's code word (queue read,
// then table read). Reset clears control state and code table valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_to_morse_keyer_unit_defines.svh"

module text_to_morse_keyer_unit
  import tmk_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = 128,
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned START_DELAY   = 100
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_code, [15:8] table_index, [31:16] table_word
  input  wire  [31:0] s_axis_tdata,
  // [1:0] req_type
  input  wire  [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [0] key_down, [1] sending, [2] push_accepted, [3] shown_valid,
  // [11:4] shown_char, [12] command_valid, [24:13] command_index, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // Configuration write port.
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned TAW = $clog2(TABLE_ENTRIES);
  localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [8:0]     TLIM  = 9'(TABLE_ENTRIES);

  // Input fields.
  logic [1:0]  req_type;
  logic [7:0]  char_code;
  logic [7:0]  table_index;
  logic [15:0] table_word;

  assign req_type    = s_axis_tuser;
  assign char_code   = s_axis_tdata[7:0];
  assign table_index = s_axis_tdata[15:8];
  assign table_word  = s_axis_tdata[31:16];

  // Configuration registers.
  logic [TIME_W-1:0] dot_q, dash_q, ptt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= 16'd60;
      dash_q <= 16'd180;
      ptt_q  <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DOT:  dot_q  <= cfg_wdata_i;
        CFG_DASH: dash_q <= cfg_wdata_i;
        CFG_PTT:  ptt_q  <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // Keyer control state.
  logic [QAW-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [1:0]      key_q, key_d;
  logic [3:0]      elem_left_q, elem_left_d;
  logic [11:0]     elem_bits_q, elem_bits_d;
  logic [CD_W-1:0] cd_q, cd_d;
  logic            gap_q, gap_d;
  logic            busy_q, busy_d;

  // Head prefetch: the character at the read pointer and its code word.
  logic [1:0]  hs_q, hs_d;
  logic [7:0]  hc_q, hc_d;
  logic [15:0] hw_q, hw_d;
  logic        tfwd_v_q, tfwd_v_d;
  logic [15:0] tfwd_w_q;
  logic        qfwd_v_q, qfwd_v_d;
  logic [7:0]  qfwd_c_q;

  // Memories and their read ports.
  logic [7:0]     qmem [QUEUE_DEPTH];
  logic [15:0]    tmem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tval_q;
  logic [7:0]     q_rdata_q;
  logic [15:0]    t_rdata_q;
  logic           t_rvalid_q;
  logic           t_oor_q;
  logic [7:0]     t_rchar;
  logic           t_we;

  // Output skid pair.
  logic        main_v_q, main_v_d, skid_v_q, skid_v_d;
  tmk_result_t main_q, main_d, skid_q, skid_d;
  tmk_result_t res;

  logic in_acc, stall, nonempty;
  logic is_tick, is_push, is_twr;
  logic push_ok, fetch;
  logic [QAW-1:0] wp_next, rp_next;
  logic [CD_W-1:0] cd_dec;
  logic [7:0]  head_char;
  logic [15:0] trd_word;
  logic        hit_hc, hit_head;

  assign nonempty = (rp_q != wp_q);
  assign wp_next  = (wp_q == QLAST) ? '0 : wp_q + 1'b1;
  assign rp_next  = (rp_q == QLAST) ? '0 : rp_q + 1'b1;

  // A tick may need the head's code word; hold it off until the word is known.
  assign stall         = (req_type == REQ_TICK) && nonempty && (hs_q != HS_READY);
  assign s_axis_tready = !skid_v_q && !stall;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign is_tick = in_acc && (req_type == REQ_TICK);
  assign is_push = in_acc && (req_type == REQ_PUSH);
  assign is_twr  = in_acc && (req_type == REQ_TWR);
  assign push_ok = is_push && (wp_next != rp_q);
  assign t_we    = is_twr && ({1'b0, table_index} < TLIM);

  // Head character as seen in the cycle after the queue read was issued;
  // a push into the empty queue is forwarded past the read-first memory.
  assign head_char = qfwd_v_q ? qfwd_c_q : q_rdata_q;
  assign t_rchar   = (hs_q == HS_QRD) ? head_char : hc_q;
  assign hit_head  = t_we && (table_index == head_char);
  assign hit_hc    = t_we && (table_index == hc_q);

  // Code word once the table read returns, with later writes forwarded.
  always_comb begin
    if (hit_hc) begin
      trd_word = table_word;
    end else if (tfwd_v_q) begin
      trd_word = tfwd_w_q;
    end else if (t_oor_q || !t_rvalid_q) begin
      trd_word = '0;
    end else begin
      trd_word = t_rdata_q;
    end
  end

  assign cd_dec = (cd_q != '0) ? cd_q - 1'b1 : '0;

  // Keyer step: timer expiry first, then a fetch from the queue on a free tick.
  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    key_d       = key_q;
    elem_left_d = elem_left_q;
    elem_bits_d = elem_bits_q;
    cd_d        = cd_q;
    gap_d       = gap_q;
    busy_d      = busy_q;
    fetch       = 1'b0;
    res         = '0;

    if (push_ok) begin
      wp_d = wp_next;
    end

    if (is_tick) begin
      cd_d = cd_dec;
      if ((cd_dec == '0) && busy_q) begin
        if (gap_q) begin
          gap_d  = 1'b0;
          busy_d = 1'b0;
        end else if (key_q == KEY_UP) begin
          if (elem_bits_q[0]) begin
            key_d = KEY_DAH;
            cd_d  = {1'b0, dash_q} + {1'b0, ptt_q};
          end else begin
            key_d = KEY_DIT;
            cd_d  = {1'b0, dot_q} + {1'b0, ptt_q};
          end
        end else begin
          key_d = KEY_UP;
          if (elem_left_q > 4'd1) begin
            elem_left_d = elem_left_q - 4'd1;
            elem_bits_d = {1'b0, elem_bits_q[11:1]};
            cd_d        = {1'b0, dot_q};
          end else begin
            elem_left_d = '0;
            cd_d        = {1'b0, dash_q};
            busy_d      = 1'b0;
          end
        end
      end

      if (!busy_d && nonempty) begin
        fetch = 1'b1;
        rp_d  = rp_next;
        if (hw_q == WORD_GAP_WORD) begin
          busy_d          = 1'b1;
          key_d           = KEY_UP;
          elem_left_d     = 4'd1;
          cd_d            = {1'b0, dash_q} + {1'b0, dot_q};
          gap_d           = 1'b1;
          res.shown_valid = 1'b1;
          res.shown_char  = SPACE_CHAR;
        end else if ((hw_q != '0) && (hw_q < WORD_GAP_WORD)) begin
          busy_d          = 1'b1;
          elem_left_d     = hw_q[15:12];
          elem_bits_d     = hw_q[11:0];
          res.shown_valid = 1'b1;
          res.shown_char  = hc_q;
        end else if (hw_q[15:12] == CMD_NIBBLE) begin
          res.command_valid = 1'b1;
          res.command_index = hw_q[11:0];
        end
      end
    end

    res.key_down      = (key_d != KEY_UP);
    res.sending       = busy_d;
    res.push_accepted = push_ok;
  end

  // Head prefetch sequencer. A fetch or a push into an empty queue restarts it;
  // otherwise it walks queue read, table read, ready.
  always_comb begin
    hs_d     = hs_q;
    hc_d     = hc_q;
    hw_d     = hw_q;
    tfwd_v_d = 1'b0;
    qfwd_v_d = push_ok && (rp_q == wp_q);
    if (fetch) begin
      hs_d = (rp_d != wp_q) ? HS_QRD : HS_IDLE;
    end else if (push_ok && !nonempty) begin
      hs_d = HS_QRD;
    end else begin
      unique case (hs_q)
        HS_QRD: begin
          hc_d     = head_char;
          tfwd_v_d = hit_head;
          hs_d     = HS_TRD;
        end
        HS_TRD: begin
          hw_d = trd_word;
          hs_d = HS_READY;
        end
        HS_READY: begin
          if (hit_hc) begin
            hw_d = table_word;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      key_q       <= KEY_UP;
      elem_left_q <= '0;
      elem_bits_q <= '0;
      cd_q        <= CD_W'(START_DELAY);
      gap_q       <= 1'b0;
      busy_q      <= 1'b0;
      hs_q        <= HS_IDLE;
      tfwd_v_q    <= 1'b0;
      qfwd_v_q    <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      key_q       <= key_d;
      elem_left_q <= elem_left_d;
      elem_bits_q <= elem_bits_d;
      cd_q        <= cd_d;
      gap_q       <= gap_d;
      busy_q      <= busy_d;
      hs_q        <= hs_d;
      tfwd_v_q    <= tfwd_v_d;
      qfwd_v_q    <= qfwd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hc_q     <= hc_d;
    hw_q     <= hw_d;
    tfwd_w_q <= table_word;
    qfwd_c_q <= char_code;
  end

  // Send queue: one write port at the write pointer, one read port that
  // always follows the next read pointer.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      qmem[wp_q] <= char_code;
    end
    q_rdata_q <= qmem[rp_d];
  end

  // Code table: data without reset, validity in flip-flops cleared at reset.
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[table_index[TAW-1:0]] <= table_word;
    end
    t_rdata_q <= tmem[t_rchar[TAW-1:0]];
    t_oor_q   <= ({1'b0, t_rchar} >= TLIM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tval_q     <= '0;
      t_rvalid_q <= 1'b0;
    end else begin
      if (t_we) begin
        tval_q[table_index[TAW-1:0]] <= 1'b1;
      end
      t_rvalid_q <= tval_q[t_rchar[TAW-1:0]];
    end
  end

  // Output register with a skid stage behind it, so a waiting result does
  // not block the next input transfer.
  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (main_v_q && m_axis_tready) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = in_acc;
        skid_d   = res;
      end else begin
        main_v_d = in_acc;
        main_d   = res;
      end
    end else if (!main_v_q) begin
      main_v_d = in_acc;
      main_d   = res;
    end else if (in_acc) begin
      skid_v_d = 1'b1;
      skid_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = main_v_q;
  assign m_axis_tdata  = {7'b0, main_q};

  // A held result in the skid stage always has one ahead of it.
  `TMK_ASSERT_IMP(a_skid_behind_main, skid_v_q, main_v_q)
  // A nonempty queue always has its head on the way or ready.
  `TMK_ASSERT_IMP(a_head_tracked, rp_q != wp_q, hs_q != HS_IDLE)
  // The key is only down while a character is being sent.
  `TMK_ASSERT_IMP(a_key_while_busy, key_q != KEY_UP, busy_q)
  // A push into the empty queue starts the head read in the next cycle.
  `TMK_ASSERT_NXT(a_push_starts_head, push_ok && (rp_q == wp_q), hs_q == HS_QRD)

endmodule

`default_nettype wire

// ===== tb/sv/text_to_morse_keyer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Text-to-Morse keyer testbench
// Sends tick, push, table write and unused requests into the keyer and checks
// every result transfer against a cycle-free model of the keyer kept here.
// The tests cover the reset timing, the special code words, a full queue,
// long random traffic under several timings, and the widest timing values.
// Both stream sides idle at random; near the end they run without gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_morse_keyer_unit_tb;
  import tmk_pkg::*;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES   = 64;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RUN_LIMIT     = 2_000_000;

  // Request code that the keyer must ignore.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Characters with a fixed meaning in the directed tests.
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_CMD   = 8'h7e;
  localparam logic [7:0] CHAR_CMDX  = 8'h7f;
  localparam logic [7:0] CHAR_SOLO  = 8'h30;
  localparam logic [7:0] CHAR_SKIP  = 8'h31;
  localparam logic [7:0] CHAR_BLANK = 8'h02;

  // --------------------------------------------------------------------------
  // Block signals.
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  text_to_morse_keyer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // Keyer model. It mirrors the architectural state of the block and is
  // stepped once for every accepted input transfer.
  // --------------------------------------------------------------------------
  logic [7:0]  send_queue [128];
  logic [6:0]  queue_head;
  logic [6:0]  queue_tail;
  logic [15:0] code_words [256];
  logic [1:0]  key_level;
  logic [3:0]  marks_left;
  logic [11:0] mark_pattern;
  logic [16:0] ticks_left;
  bit          in_word_gap;
  bit          char_active;
  logic [15:0] dot_len;
  logic [15:0] dash_len;
  logic [15:0] ptt_len;

  // Results the block still owes, oldest first.
  tmk_result_t pending_key_results[$];

  int unsigned mismatch_count;
  int unsigned result_count;
  bit          gaps_on;
  bit          hold_request;

  function automatic void clear_keyer_model();
    foreach (send_queue[i]) send_queue[i] = '0;
    foreach (code_words[i]) code_words[i] = '0;
    queue_head   = '0;
    queue_tail   = '0;
    key_level    = KEY_UP;
    marks_left   = '0;
    mark_pattern = '0;
    ticks_left   = 17'd100;
    in_word_gap  = 1'b0;
    char_active  = 1'b0;
    dot_len      = 16'd60;
    dash_len     = 16'd180;
    ptt_len      = 16'd0;
  endfunction

  // Applies one request to the model and returns the result it produces.
  function automatic tmk_result_t morse_keyer_step(logic [1:0] req, logic [7:0] ch,
                                                   logic [7:0] tidx, logic [15:0] tword);
    tmk_result_t r;
    logic [6:0]  next_tail;
    logic [7:0]  head_char;
    logic [15:0] word;
    r = '0;
    case (req)
      REQ_PUSH: begin
        next_tail = queue_tail + 7'd1;
        if (next_tail != queue_head) begin
          send_queue[queue_tail] = ch;
          queue_tail = next_tail;
          r.push_accepted = 1'b1;
        end
      end
      REQ_TWR: begin
        code_words[tidx] = tword;
      end
      REQ_TICK: begin
        if (ticks_left != '0) ticks_left = ticks_left - 17'd1;
        // The timer ran out: finish a word gap or move the key.
        if (ticks_left == '0 && char_active) begin
          if (in_word_gap) begin
            in_word_gap = 1'b0;
            char_active = 1'b0;
          end else if (key_level == KEY_UP) begin
            if (mark_pattern[0]) begin
              key_level  = KEY_DAH;
              ticks_left = 17'(dash_len) + 17'(ptt_len);
            end else begin
              key_level  = KEY_DIT;
              ticks_left = 17'(dot_len) + 17'(ptt_len);
            end
          end else begin
            key_level = KEY_UP;
            if (marks_left > 4'd1) begin
              marks_left   = marks_left - 4'd1;
              mark_pattern = mark_pattern >> 1;
              ticks_left   = 17'(dot_len);
            end else begin
              marks_left  = '0;
              ticks_left  = 17'(dash_len);
              char_active = 1'b0;
            end
          end
        end
        // An idle keyer takes the next character on the same tick.
        if (!char_active && queue_head != queue_tail) begin
          head_char  = send_queue[queue_head];
          word       = code_words[head_char];
          queue_head = queue_head + 7'd1;
          if (word == WORD_GAP_WORD) begin
            char_active    = 1'b1;
            key_level      = KEY_UP;
            marks_left     = 4'd1;
            ticks_left     = 17'(dash_len) + 17'(dot_len);
            in_word_gap    = 1'b1;
            r.shown_valid  = 1'b1;
            r.shown_char   = SPACE_CHAR;
          end else if (word != '0 && word < WORD_GAP_WORD) begin
            // A character keeps whatever gap is still counting down.
            char_active   = 1'b1;
            marks_left    = word[15:12];
            mark_pattern  = word[11:0];
            r.shown_valid = 1'b1;
            r.shown_char  = head_char;
          end else if (word[15:12] == CMD_NIBBLE) begin
            r.command_valid = 1'b1;
            r.command_index = word[11:0];
          end
        end
      end
      default: begin
      end
    endcase
    r.key_down = (key_level != KEY_UP);
    r.sending  = char_active;
    return r;
  endfunction

  // Picks a character whose table entry is empty, so it leaves the queue in
  // one tick without sending anything.
  function automatic logic [7:0] silent_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (code_words[c] != '0) c = 8'($urandom);
    return c;
  endfunction

  // Code words of every shape: characters, word gaps, commands, skipped words.
  function automatic logic [15:0] random_code_word();
    case ($urandom_range(0, 9))
      0:       return WORD_GAP_WORD;
      1:       return {CMD_NIBBLE, 12'($urandom)};
      2:       return 16'h0000;
      3:       return 16'($urandom);
      default: return {4'($urandom_range(0, 12)), 12'($urandom)};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. The receiver stalls in random bursts while gaps are on. On
  // request it holds off for a long stretch, counted here, so that the keyer
  // fills its output register and skid stage and stops taking input transfers.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned held;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
        hold_request = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("result %0d: %s", result_count, what);
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d, got %0d", field, want, got));
  endtask

  // Every result transfer is compared with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    tmk_result_t want;
    tmk_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = tmk_result_t'(m_axis_tdata[24:0]);
      if (pending_key_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%08h", m_axis_tdata));
      end else begin
        want = pending_key_results.pop_front();
        check_field("key_down", want.key_down, got.key_down);
        check_field("sending", want.sending, got.sending);
        check_field("push_accepted", want.push_accepted, got.push_accepted);
        check_field("shown_valid", want.shown_valid, got.shown_valid);
        check_field("shown_char", want.shown_char, got.shown_char);
        check_field("command_valid", want.command_valid, got.command_valid);
        check_field("command_index", want.command_index, got.command_index);
        check_field("padding", 0, m_axis_tdata[31:25]);
      end
      result_count++;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Items change at the falling edge; a transfer is taken at the
  // rising edge where tvalid and tready are both high, and the model is
  // stepped right there.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] req, logic [7:0] ch, logic [7:0] tidx,
                           logic [15:0] tword);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {tword, tidx, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_key_results.push_back(morse_keyer_step(req, ch, tidx, tword));
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic send_push(logic [7:0] ch);
    send_item(REQ_PUSH, ch, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_table_write(logic [7:0] tidx, logic [15:0] tword);
    send_item(REQ_TWR, 8'($urandom), tidx, tword);
  endtask

  // Ticks until the queue is empty, nothing is being sent and the timer has
  // run out, so the next test starts from a known quiet keyer.
  task automatic run_until_quiet();
    while (char_active || ticks_left != '0 || queue_head != queue_tail)
      send_tick();
  endtask

  // The sender stops until every outstanding result has arrived.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_key_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register writes are only issued while the keyer is drained.
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DOT:  dot_len  = value;
      CFG_DASH: dash_len = value;
      CFG_PTT:  ptt_len  = value;
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_timing(logic [15:0] dot, logic [15:0] dash, logic [15:0] ptt);
    wait_results_drained();
    write_register(CFG_DOT, dot);
    write_register(CFG_DASH, dash);
    write_register(CFG_PTT, ptt);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // One dot with the timing that reset leaves, including the start delay.
  task automatic test_reset_timing();
    send_table_write(CHAR_E, 16'h1000);
    send_push(CHAR_E);
    run_until_quiet();
  endtask

  // Each kind of code word, the table and character extremes, the zero
  // element count, and a request code that must change nothing.
  task automatic test_code_words();
    set_timing(16'd1, 16'd3, 16'd0);
    send_table_write(8'h00, 16'hffff);
    send_table_write(8'hff, 16'hcfff);
    send_table_write(CHAR_T, 16'h1001);
    send_table_write(CHAR_A, 16'h2002);
    send_table_write(SPACE_CHAR, WORD_GAP_WORD);
    send_table_write(CHAR_CMD, {CMD_NIBBLE, 12'h123});
    send_table_write(CHAR_CMDX, {CMD_NIBBLE, 12'hfff});
    send_table_write(CHAR_SOLO, 16'h0005);
    send_table_write(CHAR_SKIP, 16'hd001);
    send_push(8'h00);
    send_push(8'hff);
    send_push(CHAR_T);
    send_item(REQ_NONE, 8'hff, 8'hff, 16'hffff);
    send_push(CHAR_A);
    send_push(SPACE_CHAR);
    send_push(CHAR_CMD);
    send_push(CHAR_CMDX);
    send_push(CHAR_SOLO);
    send_push(CHAR_SKIP);
    send_push(CHAR_BLANK);
    send_push(CHAR_E);
    send_item(REQ_NONE, 8'h00, 8'h00, 16'h0000);
    run_until_quiet();
    // An empty word at the lowest index.
    send_table_write(8'h00, 16'h0000);
  endtask

  // Fills the queue past its capacity of 127 so the last pushes are dropped,
  // then empties it while the receiver holds off for a long stretch.
  task automatic test_queue_full();
    for (int k = 0; k < 130; k++)
      send_push((k % 32 == 0) ? CHAR_E : silent_char());
    hold_request = 1'b1;
    run_until_quiet();
  endtask

  // Random traffic: a small alphabet is loaded first, then most pushes send
  // real characters and word gaps, mixed with table rewrites and noise.
  task automatic test_random_traffic();
    int unsigned pick;
    logic [7:0]  ch;
    set_timing(16'd1, 16'd1, 16'd0);
    send_table_write(SPACE_CHAR, WORD_GAP_WORD);
    send_table_write(8'h23, {CMD_NIBBLE, 12'($urandom)});
    for (int c = 8'h40; c < 8'h60; c++)
      send_table_write(8'(c), {4'($urandom_range(1, 6)), 12'($urandom)});
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase != 0)
        set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 9)),
                   16'($urandom_range(0, 3)));
      // One phase runs without gaps on either side.
      gaps_on = (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_tick();
        end else if (pick < 85) begin
          case ($urandom_range(0, 7))
            0:       ch = SPACE_CHAR;
            1:       ch = 8'($urandom);
            default: ch = 8'($urandom_range(8'h40, 8'h5f));
          endcase
          send_push(ch);
        end else if (pick < 95) begin
          send_table_write(8'($urandom), random_code_word());
        end else begin
          send_item(REQ_NONE, 8'($urandom), 8'($urandom), 16'($urandom));
        end
      end
      gaps_on = 1'b1;
    end
  endtask

  // The widest timing values: the timer is loaded with the full 17-bit sum
  // of dash and transmitter delay. Both sides run without gaps from here on.
  task automatic test_timing_extremes();
    gaps_on = 1'b0;
    run_until_quiet();
    set_timing(16'hffff, 16'hffff, 16'hffff);
    send_table_write(CHAR_A, 16'h2002);
    send_table_write(CHAR_T, 16'h1001);
    send_push(CHAR_T);
    repeat (40) send_tick();
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = REQ_TICK;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_DOT;
    cfg_wdata_i    = '0;
    gaps_on        = 1'b1;
    hold_request   = 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    clear_keyer_model();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_timing();
    test_code_words();
    test_queue_full();
    test_random_traffic();
    test_timing_extremes();

    wait_results_drained();
    if (mismatch_count == 0 && pending_key_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/tmk_pkg.sv
src/text_to_morse_keyer_unit.sv
tb/sv/text_to_morse_keyer_unit_tb.sv
